@@ rtl/jatpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jatpd_pkg
// Shared types, codes and speed tables for the joystick pointer delta core.
// ----------------------------------------------------------------------------
package jatpd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    // configuration register indexes
    localparam logic [1:0] CFG_X_REST    = 2'd0;
    localparam logic [1:0] CFG_Y_REST    = 2'd1;
    localparam logic [1:0] CFG_DEAD_BAND = 2'd2;
    localparam logic [1:0] CFG_ROTATION  = 2'd3;
    localparam int         CFG_IDX_W     = 2;

    localparam int X_REST_RST    = 2048;
    localparam int Y_REST_RST    = 2048;
    localparam int DEAD_BAND_RST = 350;

    // speed levels
    localparam logic [1:0] SPD_LOW  = 2'd0;
    localparam logic [1:0] SPD_MID  = 2'd1;
    localparam logic [1:0] SPD_FAST = 2'd2;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam int LOW_DIV  = 500;
    localparam int MID_DIV  = 350;
    localparam int FAST_DIV = 220;
    localparam int LOW_LIM  = 6;
    localparam int MID_LIM  = 10;
    localparam int FAST_LIM = 18;
    localparam int MAX_LIM  = FAST_LIM;

    localparam int STEP_W    = 6;
    localparam int QMAG_W    = 5;
    localparam int SPEED_W   = 2;
    localparam int OUT_BITS  = 3 * STEP_W + SPEED_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [STEP_W-1:0] t_step;

    typedef struct packed {
        logic       en;     // pipeline advance
        logic [1:0] speed;  // speed of the beat in the first lane stage
    } t_lane_ctl;

    function automatic int spd_div(input logic [1:0] spd);
        int d;
        d = MID_DIV;
        unique case (spd)
            SPD_LOW:  d = LOW_DIV;
            SPD_FAST: d = FAST_DIV;
            default:  d = MID_DIV;
        endcase
        return d;
    endfunction

    function automatic int spd_lim(input logic [1:0] spd);
        int l;
        l = MID_LIM;
        unique case (spd)
            SPD_LOW:  l = LOW_LIM;
            SPD_FAST: l = FAST_LIM;
            default:  l = MID_LIM;
        endcase
        return l;
    endfunction

    // low -> mid -> fast -> low; the unused code falls back to low
    function automatic logic [1:0] spd_next(input logic [1:0] spd);
        logic [1:0] n;
        n = SPD_LOW;
        unique case (spd)
            SPD_LOW: n = SPD_MID;
            SPD_MID: n = SPD_FAST;
            default: n = SPD_LOW;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/jatpd_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jatpd_lane
// One axis: rest offset, dead band, scaled and clamped step in two stages.
// ----------------------------------------------------------------------------
module jatpd_lane #(
    parameter int SAMPLE_BITS = jatpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  jatpd_pkg::t_lane_ctl       i_ctl,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic [SAMPLE_BITS-1:0]     i_rest,
    input  logic [SAMPLE_BITS-1:0]     i_dead,
    output jatpd_pkg::t_step           o_step
);
    import jatpd_pkg::*;

    logic signed [SAMPLE_BITS:0] w_off;
    logic signed [SAMPLE_BITS:0] w_abs;
    logic [SAMPLE_BITS-1:0]      w_mag;
    logic                        w_neg;

    logic [SAMPLE_BITS-1:0]      r_mag;
    logic                        r_neg;
    logic                        r_zero;

    logic [QMAG_W-1:0]           w_q;
    int                          w_div;
    int                          w_lim;
    t_step                       n_step;
    t_step                       r_step;

    assign w_off = $signed({1'b0, i_sample}) - $signed({1'b0, i_rest});
    assign w_neg = w_off[SAMPLE_BITS];
    assign w_abs = w_neg ? -w_off : w_off;
    assign w_mag = w_abs[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_mag  <= w_mag;
            r_neg  <= w_neg;
            r_zero <= (w_mag < i_dead);
        end
    end

    assign w_div = spd_div(i_ctl.speed);
    assign w_lim = spd_lim(i_ctl.speed);

    // quotient already clamped: highest multiple of the divisor up to the limit
    always_comb begin
        w_q = '0;
        for (int k = 1; k <= MAX_LIM; k++) begin
            if (k <= w_lim && int'(r_mag) >= k * w_div) begin
                w_q = QMAG_W'(k);
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            n_step = '0;
        end else if (r_neg) begin
            n_step = -$signed({1'b0, w_q});
        end else begin
            n_step = $signed({1'b0, w_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

@@ rtl/jatpd_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jatpd_merge
// Combines the two axis steps: rotation, wheel step, packed output register.
// ----------------------------------------------------------------------------
module jatpd_merge (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [1:0]                        i_rot,
    input  logic [1:0]                        i_speed,
    input  jatpd_pkg::t_step                  i_mx,
    input  jatpd_pkg::t_step                  i_my,
    output logic [jatpd_pkg::M_TDATA_W-1:0]   o_tdata
);
    import jatpd_pkg::*;

    t_step w_sx;
    t_step w_sy;
    t_step w_wheel;
    logic [M_TDATA_W-1:0] r_tdata;

    always_comb begin
        unique case (i_rot)
            ROT_90: begin
                w_sx = i_my;
                w_sy = -i_mx;
            end
            ROT_180: begin
                w_sx = -i_mx;
                w_sy = -i_my;
            end
            ROT_270: begin
                w_sx = -i_my;
                w_sy = i_mx;
            end
            default: begin
                w_sx = i_mx;
                w_sy = i_my;
            end
        endcase
    end

    assign w_wheel = -i_my;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tdata <= {{(M_TDATA_W - OUT_BITS){1'b0}}, i_speed, w_wheel, w_sy, w_sx};
        end
    end

    assign o_tdata = r_tdata;

endmodule

@@ rtl/joystick_axis_to_pointer_delta_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_to_pointer_delta_core
// Turns X/Y joystick samples into rotated pointer and wheel steps.
// ----------------------------------------------------------------------------
// Takes one sample pair per clock unless a full output register stalls, and
// returns one result beat per sample. Two axis lanes run side by side
// (offset and dead band, then clamped constant-divisor quotient) and a merge
// stage applies the rotation and holds the output register. The whole
// pipeline advances whenever the output register is empty or being taken, so
// s_axis_tready follows m_axis_tready combinationally. The speed level in use
// goes out with each result and advances after a beat whose tuser flag is
// set. Configuration writes take effect at once and belong in idle periods.
module joystick_axis_to_pointer_delta_core #(
    parameter int SAMPLE_BITS = jatpd_pkg::SAMPLE_BITS_DEF,
    parameter int S_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: x_sample, y_sample, zero fill
    input  logic [S_TDATA_W-1:0]                 s_axis_tdata,
    // tuser: advance_speed
    input  logic [0:0]                           s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: step_x, step_y, wheel_step, speed_now, zero fill
    output logic [jatpd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [jatpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]               i_cfg_data
);
    import jatpd_pkg::*;

    logic [SAMPLE_BITS-1:0] r_x_rest;
    logic [SAMPLE_BITS-1:0] r_y_rest;
    logic [SAMPLE_BITS-1:0] r_dead;
    logic [1:0]             r_rot;
    logic [1:0]             r_speed;

    logic                   w_en;
    logic                   w_acc;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_vo;
    logic [1:0]             r_spd1;
    logic [1:0]             r_spd2;

    t_lane_ctl              w_ctl;
    t_step                  w_mx;
    t_step                  w_my;

    assign w_en          = !r_vo || m_axis_tready;
    assign w_acc         = s_axis_tvalid && w_en;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_rest <= SAMPLE_BITS'(X_REST_RST);
            r_y_rest <= SAMPLE_BITS'(Y_REST_RST);
            r_dead   <= SAMPLE_BITS'(DEAD_BAND_RST);
            r_rot    <= ROT_0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_X_REST:    r_x_rest <= i_cfg_data;
                CFG_Y_REST:    r_y_rest <= i_cfg_data;
                CFG_DEAD_BAND: r_dead   <= i_cfg_data;
                default:       r_rot    <= i_cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPD_MID;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_vo    <= 1'b0;
        end else begin
            if (w_acc && s_axis_tuser[0]) begin
                r_speed <= spd_next(r_speed);
            end
            if (w_en) begin
                r_v1 <= w_acc;
                r_v2 <= r_v1;
                r_vo <= r_v2;
            end
        end
    end

    // speed travels with its beat
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_spd1 <= r_speed;
            r_spd2 <= r_spd1;
        end
    end

    assign w_ctl.en    = w_en;
    assign w_ctl.speed = r_spd1;

    jatpd_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_rest   (r_x_rest),
        .i_dead   (r_dead),
        .o_step   (w_mx)
    );

    jatpd_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_rest   (r_y_rest),
        .i_dead   (r_dead),
        .o_step   (w_my)
    );

    jatpd_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_rot   (r_rot),
        .i_speed (r_spd2),
        .i_mx    (w_mx),
        .i_my    (w_my),
        .o_tdata (m_axis_tdata)
    );

endmodule

@@ rtl/jatpd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jatpd_checker
// Port-level checks on the result stream of the pointer delta core.
// ----------------------------------------------------------------------------
module jatpd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [jatpd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import jatpd_pkg::*;

    // no result beat right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    // stalled beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // the unused speed code never shows up
    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:18] != 2'd3)
        else $error("speed_now out of range");

    // low speed limits the wheel step to six
    a_low_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[19:18] == SPD_LOW |->
            $signed(m_axis_tdata[17:12]) <= 6 && $signed(m_axis_tdata[17:12]) >= -6)
        else $error("wheel step beyond low speed limit");

endmodule

bind joystick_axis_to_pointer_delta_core jatpd_checker u_jatpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joystick pointer delta core.
// ----------------------------------------------------------------------------
// Sample pairs go in on the slave stream and are run through a local
// model of the offset, dead band, divide, clamp and rotation math. That
// model keeps its own speed level and register copies. Each output beat is
// compared field by field against the oldest predicted delta. Directed
// cases cover the dead band edges, the speed cycle, clamping and
// the register extremes. Randomized traffic then runs under several
// register settings and idle mixes, and a long output stall fills the
// pipe.
module testbench;

    import jatpd_pkg::*;

    localparam int S_TDATA_W = 24;

    typedef struct packed {
        t_step      step_x;
        t_step      step_y;
        t_step      wheel;
        logic [1:0] speed;
    } t_delta;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [11:0]            i_cfg_data;

    // predictor state and register copies
    logic [11:0] x_rest_cfg;
    logic [11:0] y_rest_cfg;
    logic [11:0] dead_band_cfg;
    logic [1:0]  rotation_cfg;
    logic [1:0]  speed_level;

    t_delta pending_deltas[$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;

    joystick_axis_to_pointer_delta_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL joystick_axis_to_pointer_delta_core");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // one axis: offset from rest, dead band, truncating divide, clamp
    function automatic int axis_delta(input logic [11:0] raw, input logic [11:0] rest,
                                      input logic [1:0] spd);
        int offset, mag, divisor, limit, q;
        offset = int'(raw) - int'(rest);
        mag = (offset < 0) ? -offset : offset;
        if (mag < int'(dead_band_cfg)) begin
            return 0;
        end
        case (spd)
            SPD_LOW: begin
                divisor = LOW_DIV;
                limit   = LOW_LIM;
            end
            SPD_FAST: begin
                divisor = FAST_DIV;
                limit   = FAST_LIM;
            end
            default: begin
                divisor = MID_DIV;
                limit   = MID_LIM;
            end
        endcase
        q = offset / divisor;
        if (q > limit) begin
            q = limit;
        end else if (q < -limit) begin
            q = -limit;
        end
        return q;
    endfunction

    function automatic t_delta convert_sample(input logic [11:0] x, input logic [11:0] y,
                                              input logic adv);
        t_delta d;
        int mx, my, sx, sy, wy;
        mx = axis_delta(x, x_rest_cfg, speed_level);
        my = axis_delta(y, y_rest_cfg, speed_level);
        case (rotation_cfg)
            ROT_90: begin
                sx = my;
                sy = -mx;
            end
            ROT_180: begin
                sx = -mx;
                sy = -my;
            end
            ROT_270: begin
                sx = -my;
                sy = mx;
            end
            default: begin
                sx = mx;
                sy = my;
            end
        endcase
        wy = -my;
        d.step_x = sx[STEP_W-1:0];
        d.step_y = sy[STEP_W-1:0];
        d.wheel  = wy[STEP_W-1:0];
        d.speed  = speed_level;
        // speed moves on only after this beat's conversion
        if (adv) begin
            case (speed_level)
                SPD_LOW: speed_level = SPD_MID;
                SPD_MID: speed_level = SPD_FAST;
                default: speed_level = SPD_LOW;
            endcase
        end
        return d;
    endfunction

    task automatic send_sample(input logic [11:0] x, input logic [11:0] y, input logic adv);
        // each cycle before the offer idles with the configured odds
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= adv;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_deltas.push_back(convert_sample(x, y, adv));
    endtask

    // stop offering and let every predicted beat come out
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (pending_deltas.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_X_REST:    x_rest_cfg    = val;
            CFG_Y_REST:    y_rest_cfg    = val;
            CFG_DEAD_BAND: dead_band_cfg = val;
            default:       rotation_cfg  = val[1:0];
        endcase
    endtask

    task automatic apply_settings(input logic [11:0] xr, input logic [11:0] yr,
                                  input logic [11:0] db, input logic [1:0] rot);
        logic [11:0] rot_word;
        // upper bits of the rotation word are don't-care
        rot_word = 12'(($urandom() << 2) | rot);
        write_reg(CFG_X_REST, xr);
        write_reg(CFG_Y_REST, yr);
        write_reg(CFG_DEAD_BAND, db);
        write_reg(CFG_ROTATION, rot_word);
    endtask

    function automatic logic [11:0] pick_sample(input logic [11:0] rest);
        int v;
        if ($urandom_range(1) == 0) begin
            return 12'($urandom_range(4095));
        end
        v = int'($urandom_range(5000)) - 2500 + int'(rest);
        if (v < 0) begin
            v = 0;
        end else if (v > 4095) begin
            v = 4095;
        end
        return v[11:0];
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            m_axis_tready <= 1'b0;
            hold_req--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : chk_beat
        t_delta want;
        t_step  got_x, got_y, got_w;
        logic [1:0] got_s;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_x = m_axis_tdata[5:0];
            got_y = m_axis_tdata[11:6];
            got_w = m_axis_tdata[17:12];
            got_s = m_axis_tdata[19:18];
            if (pending_deltas.size() == 0) begin
                report_error($sformatf("beat with nothing expected, tdata %h", m_axis_tdata));
            end else begin
                want = pending_deltas.pop_front();
                if (got_x !== want.step_x) begin
                    report_error($sformatf("step_x got %0d expected %0d",
                                           got_x, want.step_x));
                end
                if (got_y !== want.step_y) begin
                    report_error($sformatf("step_y got %0d expected %0d",
                                           got_y, want.step_y));
                end
                if (got_w !== want.wheel) begin
                    report_error($sformatf("wheel_step got %0d expected %0d",
                                           got_w, want.wheel));
                end
                if (got_s !== want.speed) begin
                    report_error($sformatf("speed_now got %0d expected %0d",
                                           got_s, want.speed));
                end
            end
        end
    end

    task automatic test_dead_band_edges();
        send_sample(12'd2398, 12'd2397, 1'b0);
        send_sample(12'd1698, 12'd1699, 1'b0);
        send_sample(12'd2048, 12'd2048, 1'b0);
        send_sample(12'd0, 12'd4095, 1'b0);
        send_sample(12'd4095, 12'd0, 1'b0);
    endtask

    // mid -> fast -> low -> mid
    task automatic test_speed_cycle();
        send_sample(12'd4095, 12'd0, 1'b1);
        send_sample(12'd4095, 12'd0, 1'b1);
        send_sample(12'd0, 12'd4095, 1'b1);
        send_sample(12'd2400, 12'd1700, 1'b0);
    endtask

    task automatic test_config_extremes();
        logic [1:0] rot_codes[4];
        int k;
        rot_codes = '{ROT_0, ROT_90, ROT_180, ROT_270};
        wait_results_done();
        apply_settings(12'd0, 12'd0, 12'd0, ROT_0);
        for (k = 0; k < 4; k++) begin
            wait_results_done();
            write_reg(CFG_ROTATION, {10'd0, rot_codes[k]});
            send_sample(12'd4095, 12'd1000, 1'b0);
        end
        // full-scale input clamps at mid and low, fits at fast
        send_sample(12'd4095, 12'd4095, 1'b1);
        send_sample(12'd4095, 12'd4095, 1'b1);
        send_sample(12'd4095, 12'd4095, 1'b1);
        wait_results_done();
        apply_settings(12'd4095, 12'd4095, 12'd4095, ROT_0);
        send_sample(12'd0, 12'd0, 1'b0);
        send_sample(12'd1, 12'd4095, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
        logic [11:0] xr, yr, db;
        int k, i;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (k = 0; k < 4; k++) begin
            wait_results_done();
            xr = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                          : 12'(1800 + $urandom_range(500));
            yr = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                          : 12'(1800 + $urandom_range(500));
            case ($urandom_range(7))
                0:       db = 12'd0;
                1:       db = 12'd4095;
                default: db = 12'($urandom_range(600));
            endcase
            apply_settings(xr, yr, db, 2'($urandom_range(3)));
            for (i = 0; i < n_items / 4; i++) begin
                send_sample(pick_sample(x_rest_cfg), pick_sample(y_rest_cfg),
                            $urandom_range(3) == 0);
            end
        end
    endtask

    // long output stall while input keeps coming
    task automatic test_backpressure();
        int i;
        wait_results_done();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 80;
        for (i = 0; i < 40; i++) begin
            send_sample(pick_sample(x_rest_cfg), pick_sample(y_rest_cfg),
                        $urandom_range(3) == 0);
        end
        wait_results_done();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_X_REST;
        i_cfg_data    <= '0;
        x_rest_cfg    = 12'(X_REST_RST);
        y_rest_cfg    = 12'(Y_REST_RST);
        dead_band_cfg = 12'(DEAD_BAND_RST);
        rotation_cfg  = ROT_0;
        speed_level   = SPD_MID;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_dead_band_edges();
        test_speed_cycle();
        test_config_extremes();
        test_random_traffic(400, 10, 74);
        test_random_traffic(400, 74, 10);
        test_random_traffic(400, 0, 0);
        test_backpressure();

        wait_results_done();
        repeat (8) @(posedge i_clk);
        if (pending_deltas.size() != 0) begin
            report_error($sformatf("%0d deltas never came out", pending_deltas.size()));
        end
        if (error_count == 0) begin
            $display("PASS joystick_axis_to_pointer_delta_core");
        end else begin
            $display("FAIL joystick_axis_to_pointer_delta_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/jatpd_pkg.sv
rtl/jatpd_lane.sv
rtl/jatpd_merge.sv
rtl/joystick_axis_to_pointer_delta_core.sv
rtl/jatpd_checker.sv
sim/testbench.sv
